### rtl/blob_moment_accumulator_defines.svh
// Assertion macros used by the blob moment accumulator back end.
`ifndef BLOB_MOMENT_ACCUMULATOR_DEFINES_SVH
`define BLOB_MOMENT_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("blob moment accumulator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BMA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("blob moment accumulator check failed");

`endif

### rtl/bma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bma_pkg;
	localparam int MAX_LABELS = 4096;
	localparam int ADDR_W = $clog2(MAX_LABELS);
	localparam int CMD_W = 2;
	localparam int LABEL_W = 13;
	localparam int COORD_W = 16;
	localparam int INT_W = 21;
	localparam int CNT_W = 32;
	localparam int SUM_W = 64;
	localparam int SQ_W = 2 * COORD_W;
	localparam int P1_W = COORD_W + 1 + INT_W;
	localparam int P2_W = SQ_W + 1 + INT_W;
	localparam logic [LABEL_W-1:0] LABEL_COUNT_RESET = LABEL_W'(4096);
	localparam logic [LABEL_W-1:0] MAX_LABEL_VAL = LABEL_W'(MAX_LABELS);
	localparam logic [COORD_W-1:0] BB_MIN_INIT = COORD_W'(65534);

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ACC   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_ACC,
		OP_READ,
		OP_BAD
	} op_t;

	typedef struct packed {
		logic [CNT_W-1:0]          count;
		logic signed [SUM_W-1:0]   sum_i;
		logic signed [SUM_W-1:0]   sum_fi;
		logic signed [SUM_W-1:0]   sum_si;
		logic signed [SUM_W-1:0]   sum_ffi;
		logic signed [SUM_W-1:0]   sum_sfi;
		logic signed [SUM_W-1:0]   sum_ssi;
		logic [COORD_W-1:0]        min_row;
		logic [COORD_W-1:0]        max_row;
		logic [COORD_W-1:0]        min_col;
		logic [COORD_W-1:0]        max_col;
	} entry_t;

	typedef struct packed {
		op_t                      op;
		logic [ADDR_W-1:0]        addr;
		logic [COORD_W-1:0]       row;
		logic [COORD_W-1:0]       col;
		logic signed [INT_W-1:0]  intensity;
		logic signed [P1_W-1:0]   p_fi;
		logic signed [P1_W-1:0]   p_si;
		logic signed [P2_W-1:0]   p_ffi;
		logic signed [P2_W-1:0]   p_sfi;
		logic signed [P2_W-1:0]   p_ssi;
	} item_t;

	function automatic entry_t entry_init();
		entry_t e;
		e = '0;
		e.min_row = BB_MIN_INIT;
		e.min_col = BB_MIN_INIT;
		return e;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W-1:0] s;
		s = a + b;
		if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
			s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return s;
	endfunction
endpackage
`default_nettype wire

### rtl/bma_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bma_pix_if;
	import bma_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [LABEL_W-1:0]       label;
	logic [COORD_W-1:0]       row;
	logic [COORD_W-1:0]       col;
	logic signed [INT_W-1:0]  intensity;
	modport source (output valid, command, label, row, col, intensity, input ready);
	modport sink (input valid, command, label, row, col, intensity, output ready);
endinterface
`default_nettype wire

### rtl/bma_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bma_res_if;
	import bma_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     status;
	logic [CNT_W-1:0]         pixel_count;
	logic signed [SUM_W-1:0]  sum_i;
	logic signed [SUM_W-1:0]  sum_fi;
	logic signed [SUM_W-1:0]  sum_si;
	logic signed [SUM_W-1:0]  sum_ffi;
	logic signed [SUM_W-1:0]  sum_sfi;
	logic signed [SUM_W-1:0]  sum_ssi;
	logic [COORD_W-1:0]       min_row;
	logic [COORD_W-1:0]       max_row;
	logic [COORD_W-1:0]       min_col;
	logic [COORD_W-1:0]       max_col;
	modport source (output valid, status, pixel_count, sum_i, sum_fi, sum_si, sum_ffi,
		sum_sfi, sum_ssi, min_row, max_row, min_col, max_col, input ready);
	modport sink (input valid, status, pixel_count, sum_i, sum_fi, sum_si, sum_ffi,
		sum_sfi, sum_ssi, min_row, max_row, min_col, max_col, output ready);
endinterface
`default_nettype wire

### rtl/bma_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bma_cfg_if;
	import bma_pkg::*;
	logic                valid;
	logic                ready;
	logic [LABEL_W-1:0]  label_count;
	modport source (output valid, label_count, input ready);
	modport sink (input valid, label_count, output ready);
endinterface
`default_nettype wire

### rtl/bma_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

### rtl/bma_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bma_front (
	input  logic                        clk,
	input  logic                        arst_n,
	bma_pix_if.sink                     pix,
	input  logic [bma_pkg::LABEL_W-1:0] label_count,
	output logic                        push,
	output bma_pkg::item_t              push_item,
	input  logic                        full
);
	import bma_pkg::*;

	logic                     v_s1, v_s2;
	op_t                      op_s1, op_s2;
	logic [ADDR_W-1:0]        addr_s1, addr_s2;
	logic [COORD_W-1:0]       row_s1, row_s2, col_s1, col_s2;
	logic signed [INT_W-1:0]  int_s1, int_s2;
	logic signed [P1_W-1:0]   p_fi_s2, p_si_s2;
	logic [SQ_W-1:0]          cc_s2, rc_s2, rr_s2;

	logic                     rdy1, rdy2, adv1;
	logic                     lbl_ok, keep;
	op_t                      op_in;
	logic signed [COORD_W:0]  col_sx, row_sx;
	logic signed [P1_W-1:0]   p_fi, p_si;
	logic signed [SQ_W:0]     cc_sx, rc_sx, rr_sx;

	assign rdy2 = !v_s2 || !full;
	assign adv1 = v_s1 && rdy2;
	assign rdy1 = !v_s1 || rdy2;
	assign pix.ready = rdy1;
	assign push = v_s2 && !full;

	always_comb begin
		lbl_ok = (pix.label != '0) && (pix.label <= label_count) && (pix.label <= MAX_LABEL_VAL);
		keep = 1'b0;
		op_in = OP_BAD;
		unique case (cmd_t'(pix.command))
			CMD_CLEAR: begin
				keep = 1'b1;
				op_in = OP_CLEAR;
			end
			CMD_ACC: begin
				keep = (pix.label != '0);
				op_in = lbl_ok ? OP_ACC : OP_BAD;
			end
			CMD_READ: begin
				keep = 1'b1;
				op_in = lbl_ok ? OP_READ : OP_BAD;
			end
			CMD_NONE: begin
				keep = 1'b0;
			end
		endcase
	end

	assign col_sx = {1'b0, col_s1};
	assign row_sx = {1'b0, row_s1};
	assign p_fi = col_sx * int_s1;
	assign p_si = row_sx * int_s1;

	assign cc_sx = {1'b0, cc_s2};
	assign rc_sx = {1'b0, rc_s2};
	assign rr_sx = {1'b0, rr_s2};

	always_comb begin
		push_item.op = op_s2;
		push_item.addr = addr_s2;
		push_item.row = row_s2;
		push_item.col = col_s2;
		push_item.intensity = int_s2;
		push_item.p_fi = p_fi_s2;
		push_item.p_si = p_si_s2;
		push_item.p_ffi = cc_sx * int_s2;
		push_item.p_sfi = rc_sx * int_s2;
		push_item.p_ssi = rr_sx * int_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= pix.valid && keep;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && rdy1) begin
			op_s1 <= op_in;
			addr_s1 <= ADDR_W'(pix.label - LABEL_W'(1));
			row_s1 <= pix.row;
			col_s1 <= pix.col;
			int_s1 <= pix.intensity;
		end
		if (adv1) begin
			op_s2 <= op_s1;
			addr_s2 <= addr_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			int_s2 <= int_s1;
			p_fi_s2 <= p_fi;
			p_si_s2 <= p_si;
			cc_s2 <= col_s1 * col_s1;
			rc_s2 <= row_s1 * col_s1;
			rr_s2 <= row_s1 * row_s1;
		end
	end
endmodule
`default_nettype wire

### rtl/bma_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bma_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bma_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output bma_pkg::item_t head,
	output logic           empty
);
	import bma_pkg::*;

	item_t       slot_q [2];
	logic        wptr_q, rptr_q;
	logic [1:0]  cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end
endmodule
`default_nettype wire

### rtl/bma_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "blob_moment_accumulator_defines.svh"
module bma_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bma_pkg::item_t head,
	input  logic           empty,
	output logic           pop,
	bma_res_if.source      res
);
	import bma_pkg::*;

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD
	} state_t;

	state_t             st_q;
	logic [ADDR_W-1:0]  clr_q;
	item_t              cur_q;
	logic               out_v_q;
	logic               status_q;
	entry_t             out_q;

	logic               wr_en, rd_en;
	logic [ADDR_W-1:0]  wr_addr;
	entry_t             wr_data, rd_e, upd;
	logic [$bits(entry_t)-1:0] rd_raw;

	bma_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_LABELS)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(head.addr),
		.rd_data(rd_raw)
	);

	assign rd_e = entry_t'(rd_raw);

	assign pop = (st_q == ST_IDLE) && !empty && (head.op != OP_BAD || !out_v_q);
	assign rd_en = pop && (head.op == OP_ACC || head.op == OP_READ);
	assign wr_en = (st_q == ST_CLR) || (st_q == ST_RD && cur_q.op == OP_ACC);
	assign wr_addr = (st_q == ST_CLR) ? clr_q : cur_q.addr;
	assign wr_data = (st_q == ST_CLR) ? entry_init() : upd;

	always_comb begin
		upd = rd_e;
		if (rd_e.count != '1) begin
			upd.count = rd_e.count + CNT_W'(1);
		end
		upd.sum_i = sat_add(rd_e.sum_i, {{(SUM_W-INT_W){cur_q.intensity[INT_W-1]}},
			cur_q.intensity});
		upd.sum_fi = sat_add(rd_e.sum_fi, {{(SUM_W-P1_W){cur_q.p_fi[P1_W-1]}}, cur_q.p_fi});
		upd.sum_si = sat_add(rd_e.sum_si, {{(SUM_W-P1_W){cur_q.p_si[P1_W-1]}}, cur_q.p_si});
		upd.sum_ffi = sat_add(rd_e.sum_ffi, {{(SUM_W-P2_W){cur_q.p_ffi[P2_W-1]}},
			cur_q.p_ffi});
		upd.sum_sfi = sat_add(rd_e.sum_sfi, {{(SUM_W-P2_W){cur_q.p_sfi[P2_W-1]}},
			cur_q.p_sfi});
		upd.sum_ssi = sat_add(rd_e.sum_ssi, {{(SUM_W-P2_W){cur_q.p_ssi[P2_W-1]}},
			cur_q.p_ssi});
		if (rd_e.max_row < cur_q.row) begin
			upd.max_row = cur_q.row;
		end
		if (rd_e.max_col < cur_q.col) begin
			upd.max_col = cur_q.col;
		end
		if (rd_e.min_row > cur_q.row) begin
			upd.min_row = cur_q.row;
		end
		if (rd_e.min_col > cur_q.col) begin
			upd.min_col = cur_q.col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			status_q <= 1'b0;
			out_q <= '0;
			cur_q <= '0;
		end else begin
			if (res.valid && res.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MAX_LABELS - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						cur_q <= head;
						unique case (head.op)
							OP_CLEAR: begin
								clr_q <= '0;
								st_q <= ST_CLR;
							end
							OP_ACC, OP_READ: begin
								st_q <= ST_RD;
							end
							OP_BAD: begin
								out_v_q <= 1'b1;
								status_q <= 1'b1;
								out_q <= '0;
							end
						endcase
					end
				end
				ST_RD: begin
					if (cur_q.op == OP_ACC) begin
						st_q <= ST_IDLE;
					end else if (!out_v_q) begin
						out_v_q <= 1'b1;
						status_q <= 1'b0;
						out_q <= rd_e;
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid = out_v_q;
	assign res.status = status_q;
	assign res.pixel_count = out_q.count;
	assign res.sum_i = out_q.sum_i;
	assign res.sum_fi = out_q.sum_fi;
	assign res.sum_si = out_q.sum_si;
	assign res.sum_ffi = out_q.sum_ffi;
	assign res.sum_sfi = out_q.sum_sfi;
	assign res.sum_ssi = out_q.sum_ssi;
	assign res.min_row = out_q.min_row;
	assign res.max_row = out_q.max_row;
	assign res.min_col = out_q.min_col;
	assign res.max_col = out_q.max_col;

	`BMA_ASSERT_NOW(a_no_pop_in_sweep, clk, arst_n, st_q == ST_CLR, !pop)
	`BMA_ASSERT_NOW(a_no_read_during_write, clk, arst_n, rd_en, !wr_en)
	`BMA_ASSERT_NEXT(a_acc_two_cycles, clk, arst_n, st_q == ST_RD && cur_q.op == OP_ACC,
		st_q == ST_IDLE)
endmodule
`default_nettype wire

### rtl/blob_moment_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Role    Beat contents
// pix      sink    command, label, row, col, intensity
// res      source  status, pixel_count, six moment sums, bounding box
// cfg      sink    label_count
//
// In the back end an accumulate or read first reads the entry RAM, then does the
// update and write back or the result load. Items pass two front stages and a two-deep queue.
// After reset and after every clear command the back end sweeps all 4096 entries of the
// entry RAM and takes no item from the queue; the front keeps filling the queue meanwhile.
// A waiting result holds up the next read or out-of-range beat and every beat behind it.
module blob_moment_accumulator (
	input  logic     clk,
	input  logic     arst_n,
	bma_pix_if.sink  pix,
	bma_res_if.source res,
	bma_cfg_if.sink  cfg
);
	import bma_pkg::*;

	logic [LABEL_W-1:0] label_count_q;
	logic               push, full, pop, empty;
	item_t              push_item, head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= LABEL_COUNT_RESET;
		end else if (cfg.valid) begin
			label_count_q <= cfg.label_count;
		end
	end

	bma_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.label_count(label_count_q),
		.push(push),
		.push_item(push_item),
		.full(full)
	);

	bma_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(full),
		.pop(pop),
		.head(head),
		.empty(empty)
	);

	bma_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.res(res)
	);
endmodule
`default_nettype wire
